// ===== hdl/gact_pkg.sv =====
`timescale 1ns / 1ps
package gact_pkg;

  localparam int MAX_TRIG_DEFAULT = 16;
  localparam int QDEPTH = 2;

  localparam logic [1:0] REG_DEADBAND = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_STREAMS  = 2'd2;
  localparam logic [1:0] REG_MAXSTEP  = 2'd3;

  typedef struct packed {
    logic [62:0]        sample_time;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
  } in_t;

  typedef struct packed {
    logic [31:0] crossing_index;
    logic [5:0]  stream_index;
    logic [62:0] fire_time;
    logic        last;
    logic        overflow;
  } out_t;

  typedef struct packed {
    logic [62:0]        now;
    logic [19:0]        dt;
    logic signed [31:0] w;
  } job_t;

  typedef struct packed {
    logic [30:0] deadband_rate;
    logic [22:0] interval_angle;
    logic [6:0]  stream_count;
    logic [19:0] max_step_time;
  } cfg_t;

endpackage

// ===== hdl/gact_fifo.sv =====
`timescale 1ns / 1ps
module gact_fifo import gact_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wdata,
  output logic full,
  input  logic rd,
  output logic avail,
  output job_t rdata
);
  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  job_t          mem [QDEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] cnt;

  assign full  = (cnt == CW'(QDEPTH));
  assign avail = (cnt != '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr && !full) begin
        mem[wp] <= wdata;
        wp <= (wp == PW'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (rd && avail) begin
        rp <= (rp == PW'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + CW'(wr && !full) - CW'(rd && avail);
    end
  end
endmodule

// ===== hdl/gact_front.sv =====
`timescale 1ns / 1ps
module gact_front import gact_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic take,
  input  in_t  word,
  output logic enq,
  output job_t job
);
  logic        awaiting;
  logic [62:0] prev_time;
  logic [62:0] step;
  logic [31:0] mx, my, mz;
  logic signed [31:0] rx, ry, rz, w;
  logic        good;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  always_comb begin
    step = word.sample_time - prev_time;
    good = !awaiting && (word.sample_time > prev_time) &&
           (step <= {43'd0, cfg.max_step_time});
    mx = mag32(word.rate_x);
    my = mag32(word.rate_y);
    mz = mag32(word.rate_z);
    rx = word.rate_x;
    ry = word.rate_y;
    rz = word.rate_z;
    if (mx < {1'b0, cfg.deadband_rate}) begin
      mx = '0;
      rx = '0;
    end
    if (my < {1'b0, cfg.deadband_rate}) begin
      my = '0;
      ry = '0;
    end
    if (mz < {1'b0, cfg.deadband_rate}) begin
      mz = '0;
      rz = '0;
    end
    if (mx >= my && mx >= mz) w = rx;
    else if (my >= mz) w = ry;
    else w = rz;
    job.now = word.sample_time;
    job.dt  = step[19:0];
    job.w   = w;
    enq = take && good && (w != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting  <= 1'b1;
      prev_time <= '0;
    end else if (take) begin
      awaiting  <= 1'b0;
      prev_time <= word.sample_time;
    end
  end
endmodule

// ===== hdl/gact_back.sv =====
`timescale 1ns / 1ps
module gact_back import gact_pkg::*; #(
  parameter int MAX_TRIG = MAX_TRIG_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic avail,
  input  job_t job,
  output logic deq,
  output logic empty,
  input  logic pop,
  output out_t out_word
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_PRE  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_SDIV = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0]  state;
  logic [62:0] now;
  logic [19:0] dt;
  logic signed [31:0] w;
  logic signed [52:0] delta;
  logic signed [63:0] acc;
  logic [31:0] cd;
  logic [63:0] mag_old, after;
  logic [42:0] ipr;
  logic [6:0]  sc;
  logic [6:0]  cnt;
  logic [43:0] rem;
  logic [63:0] dv, quo;
  logic [31:0] newc;
  logic [32:0] k, lim;
  logic [63:0] target;
  logic [6:0]  sidx;
  logic [63:0] sa, sdiv;
  logic [65:0] sr;
  logic [20:0] sq;
  logic [1:0]  phase;
  logic [62:0] ttime;
  logic        ov;

  logic signed [64:0] sum;
  logic signed [63:0] acc_new;
  logic [44:0] rem_sh;
  logic [7:0]  mrem;
  logic        is_last;
  logic [42:0] ipr_new;
  logic        load;

  assign empty = !ov;
  assign deq   = (state == S_IDLE) && avail;
  assign load  = (state == S_OUT) && (!ov || pop);

  always_comb begin
    sum = 65'(acc) + 65'(delta);
    if (sum > 65'sh0_7FFF_FFFF_FFFF_FFFF) acc_new = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (sum < -65'sh0_8000_0000_0000_0000) acc_new = 64'sh8000_0000_0000_0000;
    else acc_new = sum[63:0];
    rem_sh  = {rem, dv[63]};
    mrem    = {sidx, k[cnt[5:0]]};
    is_last = (k == {1'b0, newc}) || (k == lim);
    ipr_new = 43'((cfg.interval_angle == '0 ? 23'd1 : cfg.interval_angle) * 43'd1000000);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc   <= '0;
      cd    <= '0;
      ov    <= 1'b0;
    end else begin
      if (load) ov <= 1'b1;
      else if (pop && ov) ov <= 1'b0;
      case (state)
        S_IDLE: begin
          if (avail) begin
            now   <= job.now;
            dt    <= job.dt;
            w     <= job.w;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          delta <= 53'(w * $signed({1'b0, dt}));
          ipr   <= ipr_new;
          sc    <= (cfg.stream_count == '0) ? 7'd1 :
                   (cfg.stream_count > 7'd64) ? 7'd64 : cfg.stream_count;
          state <= S_ACC;
        end
        S_ACC: begin
          mag_old <= acc[63] ? 64'(-acc) : 64'(acc);
          after   <= acc_new[63] ? 64'(-acc_new) : 64'(acc_new);
          dv      <= acc_new[63] ? 64'(-acc_new) : 64'(acc_new);
          acc     <= acc_new;
          rem     <= '0;
          quo     <= '0;
          cnt     <= 7'd63;
          state   <= S_DIV;
        end
        S_DIV: begin
          dv <= {dv[62:0], 1'b0};
          if (rem_sh >= {2'b0, ipr}) begin
            rem <= 44'(rem_sh - {2'b0, ipr});
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh[43:0];
            quo <= {quo[62:0], 1'b0};
          end
          if (cnt == '0) begin
            k      <= {1'b0, cd} + 33'd1;
            lim    <= {1'b0, cd} + 33'(MAX_TRIG);
            target <= '0;
            sidx   <= '0;
            cnt    <= 7'd32;
            state  <= S_PRE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_PRE: begin
          if (cnt == 7'd32) begin
            newc <= (quo[63:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
          end
          target <= {target[62:0], 1'b0} + (k[cnt[5:0]] ? {21'd0, ipr} : 64'd0);
          sidx   <= (mrem >= {1'b0, sc}) ? 7'(mrem - {1'b0, sc}) : mrem[6:0];
          if (cnt == '0) state <= S_CHK;
          else cnt <= cnt - 1'b1;
        end
        S_CHK: begin
          if (k <= {1'b0, newc} && k <= lim) begin
            if (after > mag_old && target >= mag_old) begin
              sa    <= after - target;
              sdiv  <= after - mag_old;
              sr    <= '0;
              sq    <= '0;
              cnt   <= 7'd20;
              phase <= 2'd0;
              state <= S_SDIV;
            end else begin
              ttime <= now;
              state <= S_OUT;
            end
          end else begin
            cd    <= newc;
            state <= S_IDLE;
          end
        end
        S_SDIV: begin
          if (phase == 2'd0) begin
            sr    <= {sr[64:0], 1'b0} + (dt[cnt[4:0]] ? {2'b0, sa} : 66'd0);
            sq    <= {sq[19:0], 1'b0};
            phase <= 2'd1;
          end else begin
            if (sr >= {2'b0, sdiv}) begin
              sr <= sr - {2'b0, sdiv};
              sq <= sq + 1'b1;
            end
            if (phase == 2'd1) begin
              phase <= 2'd2;
            end else if (cnt == '0) begin
              state <= S_OUT;
            end else begin
              cnt   <= cnt - 1'b1;
              phase <= 2'd0;
            end
          end
          if (phase == 2'd2 && cnt == '0) begin
            ttime <= now - 63'(sq + 21'(sr >= {2'b0, sdiv}));
          end
        end
        S_OUT: begin
          if (load) begin
            out_word.crossing_index <= k[31:0];
            out_word.stream_index   <= sidx[5:0];
            out_word.fire_time      <= ttime;
            out_word.last           <= is_last;
            out_word.overflow       <= is_last && ({1'b0, newc} > lim);
            if (is_last) begin
              cd    <= newc;
              state <= S_IDLE;
            end else begin
              k      <= k + 1'b1;
              target <= target + {21'd0, ipr};
              sidx   <= (sidx + 1'b1 == sc) ? '0 : sidx + 1'b1;
              state  <= S_CHK;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    ov && !pop |=> ov && $stable(out_word))
    else $error("waiting word changed");
  a_sidx: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> sidx < sc)
    else $error("stream index out of range");
  a_cap: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> k <= lim && k <= {1'b0, newc})
    else $error("crossing beyond cap");
  a_deq: assert property (@(posedge clk) disable iff (rst)
    deq |=> state == S_MUL)
    else $error("job taken without start");
`endif
endmodule

// ===== hdl/gyro_angle_crossing_trigger_top.sv =====
`timescale 1ns / 1ps
// Gyro angle crossing trigger.
// Input channel: push/full carries one sample word (time and three rates).
// A word is taken when push is high and full is low.
// Result channel: empty/pop; the oldest result word sits on out_word while
// empty is low and leaves on a cycle with pop high.
// Configuration: cfg_we, cfg_index, cfg_data write one register per cycle;
// write only while no sample is in flight.
// The front stage classifies a sample in the cycle it is taken and queues
// integrating samples in a two-entry queue; others cause no result.
// The back stage handles each integrating sample in turn: take, multiply,
// saturating add, 64-step division, 33-step multiply and modulo; then, per
// crossing, a check and, where the magnitude grew and the target is at least
// the old magnitude, the interpolation divider (21 bits, shift-add and
// compare-and-subtract per bit).
// Reset clears the queue, the result register, the accumulator and the
// crossing count and loads register defaults; the first sample sets time only.
// While pop is held low the back stage stalls on its result register and the
// queue fills, after which full rises.
module gyro_angle_crossing_trigger_top import gact_pkg::*; #(
  parameter int MAX_TRIG = MAX_TRIG_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_t         in_word,
  output logic        empty,
  input  logic        pop,
  output out_t        out_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  cfg_t cfg;
  logic enq, deq, avail;
  job_t job_in, job_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadband_rate  <= 31'd50000;
      cfg.interval_angle <= 23'd1570796;
      cfg.stream_count   <= 7'd4;
      cfg.max_step_time  <= 20'd100000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEADBAND: cfg.deadband_rate  <= cfg_data;
        REG_INTERVAL: cfg.interval_angle <= cfg_data[22:0];
        REG_STREAMS:  cfg.stream_count   <= cfg_data[6:0];
        REG_MAXSTEP:  cfg.max_step_time  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  gact_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .take(push && !full), .word(in_word),
    .enq(enq), .job(job_in)
  );

  gact_fifo u_fifo (
    .clk(clk), .rst(rst), .wr(enq), .wdata(job_in), .full(full),
    .rd(deq), .avail(avail), .rdata(job_out)
  );

  gact_back #(.MAX_TRIG(MAX_TRIG)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .avail(avail), .job(job_out), .deq(deq),
    .empty(empty), .pop(pop), .out_word(out_word)
  );
endmodule
